// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker; clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BIF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BIF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/bif_pkg.sv -----
// ----------------------------------------------------------------------------
// bif_pkg
// types and constants of the bitmap index filter
// ----------------------------------------------------------------------------
package bif_pkg;

	localparam int MAX_ROWS_DEF   = 4096;
	localparam int VALUE_BITS_DEF = 32;
	localparam int WORD_BITS      = 64;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_RANGE  = 3'd2,
		CMD_MEMBER = 3'd3,
		CMD_LOOKUP = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		OP_LT      = 3'd0,
		OP_LE      = 3'd1,
		OP_GT      = 3'd2,
		OP_GE      = 3'd3,
		OP_BETWEEN = 3'd4
	} range_op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LOOKUP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic clear_all;
		logic rd;
		logic wr;
		logic drop;
	} acc_ctl_t;

endpackage

// ----- hdl/bif_row_store.sv -----
// ----------------------------------------------------------------------------
// bif_row_store
// row value memory, one write and one registered read port
// ----------------------------------------------------------------------------
module bif_row_store #(
	parameter int DEPTH = bif_pkg::MAX_ROWS_DEF,
	parameter int WIDTH = bif_pkg::VALUE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/bif_acc_store.sv -----
// ----------------------------------------------------------------------------
// bif_acc_store
// set member accumulator, one bitmap word per entry, valid bit per word
// ----------------------------------------------------------------------------
module bif_acc_store #(
	parameter int WORDS = 64,
	localparam int WW   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bif_pkg::acc_ctl_t             ctl,
	input  logic [WW-1:0]                 rd_addr,
	input  logic [WW-1:0]                 wr_addr,
	input  logic [bif_pkg::WORD_BITS-1:0] wr_data,
	output logic [bif_pkg::WORD_BITS-1:0] rd_data
);

	logic [bif_pkg::WORD_BITS-1:0] mem [WORDS];
	logic [bif_pkg::WORD_BITS-1:0] rd_word_q;
	logic [WORDS-1:0]              valid_q;
	logic                          rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.rd) begin
				rd_valid_q <= valid_q[rd_addr];
			end
			if (ctl.clear_all) begin
				valid_q <= '0;
			end else if (ctl.wr) begin
				valid_q[wr_addr] <= 1'b1;
			end else if (ctl.drop) begin
				valid_q[wr_addr] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

// ----- hdl/bitmap_index_filter.sv -----
// ----------------------------------------------------------------------------
// bitmap_index_filter
// column value index: append rows, range and set queries returning bitmap
// words, reverse lookup of a row value
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  command   cmd_valid/cmd_stall   command value upper_bound lower_inclusive
//                                  upper_inclusive range_op negate last_member
//                                  row_index
//  result    res_valid/res_stall   status word_index bitmap_word last lookup_value
//
//  range query or set member: one row a cycle, unless a result stall holds the
//  scan, via the row memory read port and shared comparator; one word out per
//  64 rows (range, last set member only); other results are a single word
//  result stalls hold the scan at a word boundary; cmd_stall is high while busy
//  no clearing pass after reset, the row memory is read only below row_count
// ----------------------------------------------------------------------------
module bitmap_index_filter #(
	parameter int MAX_ROWS   = bif_pkg::MAX_ROWS_DEF,
	parameter int VALUE_BITS = bif_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	input  logic signed [31:0] upper_bound,
	input  logic               lower_inclusive,
	input  logic               upper_inclusive,
	input  logic [2:0]         range_op,
	input  logic               negate,
	input  logic               last_member,
	input  logic [11:0]        row_index,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [1:0]         status,
	output logic [5:0]         word_index,
	output logic [63:0]        bitmap_word,
	output logic               last,
	output logic signed [31:0] lookup_value
);

	localparam int AW     = $clog2(MAX_ROWS);
	localparam int CW     = $clog2(MAX_ROWS + 1);
	localparam int NWORDS = (MAX_ROWS + 63) / 64;
	localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam logic [VALUE_BITS-1:0] SIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	bif_pkg::state_t    state_q, state_d;
	bif_pkg::cmd_t      cmd_q;
	bif_pkg::range_op_t op_q;
	bif_pkg::status_t   resp_status_q, resp_status_d;
	bif_pkg::acc_ctl_t  acc_ctl;

	logic [VALUE_BITS-1:0] lo_key_q, hi_key_q, lo_key_in, hi_key_in, rd_data;
	logic [63:0]           value_ext, upper_ext;
	logic                  li_q, ui_q, neg_q, lastm_q;
	logic [CW-1:0]         row_count_q, addr_q;
	logic [AW-1:0]         s1_row_q, row_raddr;
	logic                  s1_valid_q, s1_last_q;
	logic [63:0]           word_q, word_next, acc_rdata, word_mask, acc_word, push_bits;
	logic [31:0]           resp_lv_q, lv_ext;
	logic [VALUE_BITS-1:0] lv_raw;
	logic [5:0]            pos;

	logic       res_valid_q, last_q;
	logic [1:0] status_q;
	logic [5:0] word_index_q;
	logic [63:0] bitmap_q;
	logic [31:0] lookup_q;

	logic accept, out_free, full, empty, out_of_range, issuing, wend, push_cmd, advance;
	logic match, lt_lo, eq_lo, le_hi, eq_hi;
	logic row_we, row_re, cnt_clr, cnt_inc, resp_set, scan_start, lookup_done;
	logic out_single, scan_push;

	assign value_ext  = 64'(value);
	assign upper_ext  = 64'(upper_bound);
	assign lo_key_in  = value_ext[VALUE_BITS-1:0] ^ SIGN;
	assign hi_key_in  = upper_ext[VALUE_BITS-1:0] ^ SIGN;

	assign cmd_stall    = (state_q != bif_pkg::S_IDLE);
	assign accept       = cmd_valid && !cmd_stall;
	assign out_free     = !res_valid_q || !res_stall;
	assign full         = (row_count_q == CW'(MAX_ROWS));
	assign empty        = (row_count_q == '0);
	assign out_of_range = ({1'b0, row_index} >= 13'(row_count_q));
	assign issuing      = (addr_q < row_count_q);

	// shared comparator
	assign lt_lo = rd_data < lo_key_q;
	assign eq_lo = rd_data == lo_key_q;
	assign le_hi = rd_data <= hi_key_q;
	assign eq_hi = rd_data == hi_key_q;

	always_comb begin
		match = 1'b0;
		if (cmd_q == bif_pkg::CMD_MEMBER) begin
			match = eq_lo;
		end else begin
			unique case (op_q)
				bif_pkg::OP_LT:      match = lt_lo;
				bif_pkg::OP_LE:      match = lt_lo || eq_lo;
				bif_pkg::OP_GT:      match = !(lt_lo || eq_lo);
				bif_pkg::OP_GE:      match = !lt_lo;
				bif_pkg::OP_BETWEEN: match = (li_q ? !lt_lo : !(lt_lo || eq_lo)) &&
				                             (ui_q ? le_hi : (le_hi && !eq_hi));
				default:             match = 1'b0;
			endcase
		end
	end

	assign pos       = s1_row_q[5:0];
	assign wend      = (pos == 6'd63) || s1_last_q;
	assign word_next = ((pos == 6'd0) ? 64'd0 : word_q) | (64'd1 << pos);
	assign word_mask = {64{1'b1}} >> (6'd63 - pos);
	assign acc_word  = acc_rdata | (match ? word_next : ((pos == 6'd0) ? 64'd0 : word_q));
	assign push_cmd  = (cmd_q == bif_pkg::CMD_RANGE) || lastm_q;
	assign advance   = !(s1_valid_q && wend && push_cmd && !out_free);

	logic [63:0] word_built;
	assign word_built = match ? word_next : ((pos == 6'd0) ? 64'd0 : word_q);

	always_comb begin
		if (cmd_q == bif_pkg::CMD_MEMBER) begin
			push_bits = neg_q ? (~acc_word & word_mask) : acc_word;
		end else begin
			push_bits = word_built;
		end
	end

	assign lv_raw = rd_data ^ SIGN;
	generate
		if (VALUE_BITS >= 32) begin : g_lv_wide
			assign lv_ext = lv_raw[31:0];
		end else begin : g_lv_narrow
			assign lv_ext = {{(32-VALUE_BITS){lv_raw[VALUE_BITS-1]}}, lv_raw};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bif_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		row_we        = 1'b0;
		row_re        = 1'b0;
		row_raddr     = AW'(row_index);
		acc_ctl       = '0;
		resp_set      = 1'b0;
		resp_status_d = bif_pkg::STAT_OK;
		cnt_clr       = 1'b0;
		cnt_inc       = 1'b0;
		scan_start    = 1'b0;
		lookup_done   = 1'b0;
		out_single    = 1'b0;
		scan_push     = 1'b0;
		unique case (state_q)
			bif_pkg::S_IDLE: begin
				if (accept) begin
					unique case (bif_pkg::cmd_t'(command))
						bif_pkg::CMD_CLEAR: begin
							cnt_clr           = 1'b1;
							acc_ctl.clear_all = 1'b1;
							resp_set          = 1'b1;
							state_d           = bif_pkg::S_RESP;
						end
						bif_pkg::CMD_APPEND: begin
							resp_set = 1'b1;
							state_d  = bif_pkg::S_RESP;
							if (full) begin
								resp_status_d = bif_pkg::STAT_FULL;
							end else begin
								row_we  = 1'b1;
								cnt_inc = 1'b1;
							end
						end
						bif_pkg::CMD_RANGE: begin
							if (empty) begin
								resp_set      = 1'b1;
								resp_status_d = bif_pkg::STAT_EMPTY;
								state_d       = bif_pkg::S_RESP;
							end else begin
								scan_start = 1'b1;
								state_d    = bif_pkg::S_SCAN;
							end
						end
						bif_pkg::CMD_MEMBER: begin
							if (!empty) begin
								scan_start = 1'b1;
								state_d    = bif_pkg::S_SCAN;
							end else if (last_member) begin
								acc_ctl.clear_all = 1'b1;
								resp_set          = 1'b1;
								resp_status_d     = bif_pkg::STAT_EMPTY;
								state_d           = bif_pkg::S_RESP;
							end
						end
						bif_pkg::CMD_LOOKUP: begin
							if (empty) begin
								resp_set      = 1'b1;
								resp_status_d = bif_pkg::STAT_EMPTY;
								state_d       = bif_pkg::S_RESP;
							end else if (out_of_range) begin
								resp_set      = 1'b1;
								resp_status_d = bif_pkg::STAT_RANGE;
								state_d       = bif_pkg::S_RESP;
							end else begin
								row_re  = 1'b1;
								state_d = bif_pkg::S_LOOKUP;
							end
						end
						default: ;
					endcase
				end
			end
			bif_pkg::S_LOOKUP: begin
				lookup_done = 1'b1;
				state_d     = bif_pkg::S_RESP;
			end
			bif_pkg::S_RESP: begin
				if (out_free) begin
					out_single = 1'b1;
					state_d    = bif_pkg::S_IDLE;
				end
			end
			bif_pkg::S_SCAN: begin
				if (advance && issuing) begin
					row_re    = 1'b1;
					row_raddr = addr_q[AW-1:0];
					acc_ctl.rd = (addr_q[5:0] == 6'd0);
				end
				if (advance && s1_valid_q && wend) begin
					if (cmd_q == bif_pkg::CMD_MEMBER) begin
						acc_ctl.drop = lastm_q;
						acc_ctl.wr   = !lastm_q;
					end
					scan_push = push_cmd;
				end
				if (advance && s1_valid_q && s1_last_q) begin
					state_d = bif_pkg::S_IDLE;
				end
			end
			default: state_d = bif_pkg::S_IDLE;
		endcase
	end

	// item fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= bif_pkg::cmd_t'(command);
			op_q     <= bif_pkg::range_op_t'(range_op);
			lo_key_q <= lo_key_in;
			hi_key_q <= hi_key_in;
			li_q     <= lower_inclusive;
			ui_q     <= upper_inclusive;
			neg_q    <= negate;
			lastm_q  <= last_member;
		end
		if (resp_set) begin
			resp_status_q <= resp_status_d;
			resp_lv_q     <= '0;
		end else if (lookup_done) begin
			resp_status_q <= bif_pkg::STAT_OK;
			resp_lv_q     <= lv_ext;
		end
		if (state_q == bif_pkg::S_SCAN && advance) begin
			s1_row_q  <= addr_q[AW-1:0];
			s1_last_q <= (addr_q == row_count_q - CW'(1));
			if (s1_valid_q) begin
				word_q <= word_built;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			addr_q      <= '0;
			s1_valid_q  <= 1'b0;
		end else begin
			if (cnt_clr) begin
				row_count_q <= '0;
			end else if (cnt_inc) begin
				row_count_q <= row_count_q + CW'(1);
			end
			if (scan_start) begin
				addr_q     <= '0;
				s1_valid_q <= 1'b0;
			end else if (state_q == bif_pkg::S_SCAN && advance) begin
				s1_valid_q <= issuing;
				if (issuing) begin
					addr_q <= addr_q + CW'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_single || scan_push) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_single) begin
			status_q     <= resp_status_q;
			word_index_q <= '0;
			bitmap_q     <= '0;
			last_q       <= 1'b1;
			lookup_q     <= resp_lv_q;
		end else if (scan_push) begin
			status_q     <= bif_pkg::STAT_OK;
			word_index_q <= 6'(s1_row_q >> 6);
			bitmap_q     <= push_bits;
			last_q       <= s1_last_q;
			lookup_q     <= '0;
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign word_index   = word_index_q;
	assign bitmap_word  = bitmap_q;
	assign last         = last_q;
	assign lookup_value = signed'(lookup_q);

	bif_row_store #(
		.DEPTH (MAX_ROWS),
		.WIDTH (VALUE_BITS)
	) u_rows (
		.clk     (clk),
		.wr_en   (row_we),
		.wr_addr (row_count_q[AW-1:0]),
		.wr_data (lo_key_in),
		.rd_en   (row_re),
		.rd_addr (row_raddr),
		.rd_data (rd_data)
	);

	bif_acc_store #(
		.WORDS (NWORDS)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (acc_ctl),
		.rd_addr (WW'(addr_q >> 6)),
		.wr_addr (WW'(s1_row_q >> 6)),
		.wr_data (acc_word),
		.rd_data (acc_rdata)
	);

endmodule

// ----- hdl/bif_checker.sv -----
// ----------------------------------------------------------------------------
// bif_checker
// port level checks on the bitmap index filter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bif_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input logic               res_valid,
	input logic               res_stall,
	input logic [1:0]         status,
	input logic [5:0]         word_index,
	input logic [63:0]        bitmap_word,
	input logic               last,
	input logic signed [31:0] lookup_value
);

	`BIF_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(bitmap_word) && $stable(last) && $stable(word_index), "stalled result word changed")
	`BIF_ASSERT_IMP(a_mid_word_ok, res_valid && !last, status == bif_pkg::STAT_OK && lookup_value == 32'sd0, "non-final word carries status or lookup value")
	`BIF_ASSERT_IMP(a_err_single, res_valid && status != bif_pkg::STAT_OK, last && bitmap_word == 64'd0 && word_index == 6'd0, "error result is not a single empty word")
	`BIF_ASSERT_IMP(a_busy_after_take, $rose(cmd_stall), $past(cmd_valid), "busy without a word taken")

endmodule

bind bitmap_index_filter bif_checker u_bif_checker (.*);
